// ----- hw/rtl/mp2d_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types and constants of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

    // Default sizes of the line store.
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_POOL  = 4;

    // Upper bounds of the configuration registers.
    localparam int H_LIMIT = 4096;
    localparam int W_LIMIT = 1024;
    localparam int C_LIMIT = 4096;
    localparam int P_LIMIT = 4;
    localparam int S_LIMIT = 4;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int H_W        = 13;
    localparam int W_W        = 11;
    localparam int C_W        = 13;
    localparam int POOL_W     = 3;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int PLANE_W    = 12;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_STRIDE   = 3'd4;

    // Configuration as used by the datapath, already saturated into range.
    typedef struct packed {
        logic [H_W-1:0]    image_height;
        logic [W_W-1:0]    image_width;
        logic [C_W-1:0]    channel_count;
        logic [POOL_W-1:0] pool_size;
        logic [POOL_W-1:0] pool_stride;
    } cfg_t;

    // What the position tracker knows about the current pixel.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] col;
    } pos_info_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_READ,
        W_HOLD
    } win_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mp2d_ram.sv -----
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mp2d_pos.sv -----
// ----------------------------------------------------------------------------
// mp2d_pos
// Row, column, plane and stride-phase counters; decides whether the current
// pixel closes a pooling window and whether that window ends the tensor.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_pos #(
    parameter int MAX_POOL = mp2d_pkg::DEF_MAX_POOL
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mp2d_pkg::cfg_t              cfg,
    input  wire logic                        step,
    output mp2d_pkg::pos_info_t              info,
    output logic [$clog2(MAX_POOL)-1:0]      slot
);

    localparam int SW = $clog2(MAX_POOL);
    localparam int RW = mp2d_pkg::ROW_W;
    localparam int CW = mp2d_pkg::COL_W;
    localparam int NW = mp2d_pkg::PLANE_W;
    localparam int HW = mp2d_pkg::H_W;
    localparam int WW = mp2d_pkg::W_W;
    localparam int KW = mp2d_pkg::C_W;
    localparam int FW = mp2d_pkg::PHASE_W;

    logic [RW-1:0] row_reg,       row_next;
    logic [CW-1:0] col_reg,       col_next;
    logic [NW-1:0] plane_reg,     plane_next;
    logic [FW-1:0] row_phase_reg, row_phase_next;
    logic [FW-1:0] col_phase_reg, col_phase_next;
    logic [SW-1:0] slot_reg,      slot_next;

    logic [RW:0]   row_inc;
    logic [CW:0]   col_inc;
    logic [NW:0]   plane_inc;
    logic [FW:0]   row_phase_inc;
    logic [FW:0]   col_phase_inc;
    logic          in_grid_row;
    logic          in_grid_col;
    logic          fits;
    logic          row_end;
    logic          col_end;

    assign row_inc       = {1'b0, row_reg} + (RW + 1)'(1);
    assign col_inc       = {1'b0, col_reg} + (CW + 1)'(1);
    assign plane_inc     = {1'b0, plane_reg} + (NW + 1)'(1);
    assign row_phase_inc = {1'b0, row_phase_reg} + (FW + 1)'(1);
    assign col_phase_inc = {1'b0, col_phase_reg} + (FW + 1)'(1);

    assign in_grid_row = row_inc >= (RW + 1)'(cfg.pool_size);
    assign in_grid_col = col_inc >= (CW + 1)'(cfg.pool_size);
    assign fits        = (HW'(cfg.pool_size) <= cfg.image_height)
                      && (WW'(cfg.pool_size) <= cfg.image_width);
    assign col_end     = WW'(col_inc) >= cfg.image_width;
    assign row_end     = HW'(row_inc) >= cfg.image_height;

    always_comb
    begin
        info.col  = col_reg;
        info.emit = in_grid_col && in_grid_row && fits
                 && (row_phase_reg == '0) && (col_phase_reg == '0);
        info.last = (KW'(plane_inc) >= cfg.channel_count)
                 && ((14'(row_reg) + 14'(cfg.pool_stride)) >= 14'(cfg.image_height))
                 && ((12'(col_reg) + 12'(cfg.pool_stride)) >= 12'(cfg.image_width));
    end

    assign slot = slot_reg;

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        plane_next     = plane_reg;
        row_phase_next = row_phase_reg;
        col_phase_next = col_phase_reg;
        slot_next      = slot_reg;
        if (step)
        begin
            if (in_grid_col)
            begin
                col_phase_next = (3'(col_phase_inc) >= cfg.pool_stride)
                               ? '0 : FW'(col_phase_inc);
            end
            if (col_end)
            begin
                col_next       = '0;
                col_phase_next = '0;
                if (in_grid_row)
                begin
                    row_phase_next = (3'(row_phase_inc) >= cfg.pool_stride)
                                   ? '0 : FW'(row_phase_inc);
                end
                if (row_end)
                begin
                    row_next       = '0;
                    row_phase_next = '0;
                    slot_next      = '0;
                    plane_next     = (KW'(plane_inc) >= cfg.channel_count)
                                   ? '0 : NW'(plane_inc);
                end
                else
                begin
                    row_next  = RW'(row_inc);
                    // The slot follows the row number modulo the bank count.
                    slot_next = (slot_reg == SW'(MAX_POOL - 1)) ? '0 : slot_reg + SW'(1);
                end
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            plane_reg     <= '0;
            row_phase_reg <= '0;
            col_phase_reg <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            plane_reg     <= plane_next;
            row_phase_reg <= row_phase_next;
            col_phase_reg <= col_phase_next;
            slot_reg      <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mp2d_win.sv -----
// ----------------------------------------------------------------------------
// mp2d_win
// Banked line store, one bank per row slot. Writes each pixel, then reads
// a closed window one column per cycle across all banks and keeps the
// running maximum. Holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_win #(
    parameter int MAX_WIDTH = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL  = mp2d_pkg::DEF_MAX_POOL
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mp2d_pkg::PIX_W-1:0]    pixel,
    input  wire mp2d_pkg::pos_info_t           info,
    input  wire logic [$clog2(MAX_POOL)-1:0]   slot,
    input  wire logic [mp2d_pkg::POOL_W-1:0]   pool_size,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [mp2d_pkg::PIX_W-1:0]         pooled,
    output logic                               tensor_end
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(MAX_POOL);
    localparam int DW    = SW + 1;
    localparam int PW    = mp2d_pkg::POOL_W;
    localparam int XW    = mp2d_pkg::PIX_W;
    localparam int CW    = mp2d_pkg::COL_W;
    localparam int P_MAX = (MAX_POOL < mp2d_pkg::P_LIMIT) ? MAX_POOL : mp2d_pkg::P_LIMIT;
    localparam int JW    = $clog2(P_MAX);

    mp2d_pkg::win_state_t state_reg, state_next;

    logic [CW-1:0]       col_reg,       col_next;
    logic [MAX_POOL-1:0] mask_reg,      mask_next;
    logic [JW-1:0]       j_reg,         j_next;
    logic [PW-1:0]       p_reg,         p_next;
    logic [XW-1:0]       best_reg,      best_next;
    logic                last_reg,      last_next;
    logic                rd_valid_reg,  rd_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [XW-1:0]       pooled_reg,    pooled_next;
    logic                tend_reg,      tend_next;

    logic                accept;
    logic                rd_en;
    logic                load;
    logic                last_col;
    logic [AW-1:0]       rd_addr;
    logic [MAX_POOL-1:0] win_mask;
    logic [DW-1:0]       ring_dist;
    logic [XW-1:0]       col_max;
    logic [XW-1:0]       bank_q [MAX_POOL];

    assign accept   = in_valid && in_ready;
    assign last_col = (PW'(j_reg) + PW'(1)) >= p_reg;
    assign rd_addr  = AW'(col_reg - CW'(j_reg));

    // A bank belongs to the window when its row lies less than pool_size
    // rows above the current one, counting around the ring of slots.
    always_comb
    begin
        win_mask  = '0;
        ring_dist = '0;
        for (int b = 0; b < MAX_POOL; b++)
        begin
            if (slot >= SW'(b))
            begin
                ring_dist = {1'b0, slot} - DW'(b);
            end
            else
            begin
                ring_dist = {1'b0, slot} + DW'(MAX_POOL - b);
            end
            win_mask[b] = int'(ring_dist) < int'(pool_size);
        end
    end

    for (genvar g = 0; g < MAX_POOL; g++)
    begin : g_bank
        mp2d_ram #(
            .WIDTH(XW),
            .DEPTH(MAX_WIDTH)
        ) u_bank (
            .clk  (clk),
            .we   (accept && (slot == SW'(g))),
            .waddr(AW'(info.col)),
            .wdata(pixel),
            .re   (rd_en),
            .raddr(rd_addr),
            .rdata(bank_q[g])
        );
    end

    always_comb
    begin
        col_max = '0;
        for (int b = 0; b < MAX_POOL; b++)
        begin
            if (mask_reg[b] && (bank_q[b] > col_max))
            begin
                col_max = bank_q[b];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mp2d_pkg::W_IDLE:
            begin
                if (accept && info.emit)
                begin
                    state_next = mp2d_pkg::W_READ;
                end
            end
            mp2d_pkg::W_READ:
            begin
                if (last_col)
                begin
                    state_next = mp2d_pkg::W_HOLD;
                end
            end
            mp2d_pkg::W_HOLD:
            begin
                if (load)
                begin
                    state_next = mp2d_pkg::W_IDLE;
                end
            end
            default:
            begin
                state_next = mp2d_pkg::W_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            mp2d_pkg::W_IDLE:
            begin
                in_ready = 1'b1;
            end
            mp2d_pkg::W_READ:
            begin
                rd_en = 1'b1;
            end
            mp2d_pkg::W_HOLD:
            begin
                load = !rd_valid_reg && (!out_valid_reg || out_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        col_next       = col_reg;
        mask_next      = mask_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        best_next      = best_reg;
        last_next      = last_reg;
        rd_valid_next  = rd_en;
        out_valid_next = out_valid_reg;
        pooled_next    = pooled_reg;
        tend_next      = tend_reg;

        if (accept && info.emit)
        begin
            col_next  = info.col;
            mask_next = win_mask;
            j_next    = '0;
            p_next    = pool_size;
            best_next = '0;
            last_next = info.last;
        end
        else if (rd_valid_reg && (col_max > best_reg))
        begin
            best_next = col_max;
        end

        if (rd_en)
        begin
            j_next = j_reg + JW'(1);
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            pooled_next    = best_reg;
            tend_next      = last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mp2d_pkg::W_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        mask_reg   <= mask_next;
        j_reg      <= j_next;
        p_reg      <= p_next;
        best_reg   <= best_next;
        last_reg   <= last_next;
        pooled_reg <= pooled_next;
        tend_reg   <= tend_next;
    end

    assign out_valid  = out_valid_reg;
    assign pooled     = pooled_reg;
    assign tensor_end = tend_reg;

    // A new pixel must never overwrite the store while a window read is in flight.
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rd_valid_reg)
        else $error("pixel accepted while a window read is outstanding");

    a_col_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mp2d_pkg::W_READ) |-> (PW'(j_reg) < p_reg))
        else $error("column step beyond the window");

    a_mask_has_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mp2d_pkg::W_READ) |-> (mask_reg != '0))
        else $error("window read with no row selected");

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(rd_en))
        else $error("read data marked valid without a read request");

endmodule

`default_nettype wire

// ----- hw/rtl/max_pool_2d_u8_stream.sv -----
// ----------------------------------------------------------------------------
// max_pool_2d_u8_stream
// Streaming 2-D max pooling of 8-bit channel-planar images with a banked
// line store and a per-column window read.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Content
//  input     in         in_valid / in_ready              pixel
//  output    out        out_valid / out_ready            pooled, tensor_end
//  config    in         cfg_valid / cfg_ready            cfg_index, cfg_data
//
//  A pixel that closes no window is taken and the next one can follow at once.
//  A pixel that closes a window is written, then the window is read column by
//  column from all row banks in parallel, the last read data is taken in and
//  the output register is loaded; no new pixel is taken until that is done.
//  Reset is asynchronous and clears counters and handshake state; the line store
//  is not cleared. A stalled output does not block the next pixel unless a new
//  result is ready to take its place.
//
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_u8_stream #(
    parameter int MAX_WIDTH = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL  = mp2d_pkg::DEF_MAX_POOL
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mp2d_pkg::PIX_W-1:0]        pixel,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mp2d_pkg::PIX_W-1:0]             pooled,
    output logic                                   tensor_end,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int HW    = mp2d_pkg::H_W;
    localparam int WW    = mp2d_pkg::W_W;
    localparam int KW    = mp2d_pkg::C_W;
    localparam int PW    = mp2d_pkg::POOL_W;
    localparam int W_MAX = (MAX_WIDTH < mp2d_pkg::W_LIMIT) ? MAX_WIDTH : mp2d_pkg::W_LIMIT;
    localparam int P_MAX = (MAX_POOL < mp2d_pkg::P_LIMIT) ? MAX_POOL : mp2d_pkg::P_LIMIT;

    mp2d_pkg::cfg_t       cfg_reg, cfg_next;
    mp2d_pkg::pos_info_t  info;
    logic [$clog2(MAX_POOL)-1:0] slot;
    logic                 step;
    logic                 cfg_wr;
    logic [HW-1:0]        wr_h;
    logic [WW-1:0]        wr_w;
    logic [KW-1:0]        wr_c;
    logic [PW-1:0]        wr_p;
    logic [PW-1:0]        wr_s;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign step      = in_valid && in_ready;

    assign wr_h = cfg_data[HW-1:0];
    assign wr_w = cfg_data[WW-1:0];
    assign wr_c = cfg_data[KW-1:0];
    assign wr_p = cfg_data[PW-1:0];
    assign wr_s = cfg_data[PW-1:0];

    // Registers hold their values saturated into range, so the datapath
    // never sees zero or an oversized value.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                mp2d_pkg::REG_IMAGE_HEIGHT:
                begin
                    cfg_next.image_height = (wr_h == '0) ? HW'(1)
                        : (wr_h > HW'(mp2d_pkg::H_LIMIT)) ? HW'(mp2d_pkg::H_LIMIT) : wr_h;
                end
                mp2d_pkg::REG_IMAGE_WIDTH:
                begin
                    cfg_next.image_width = (wr_w == '0) ? WW'(1)
                        : (wr_w > WW'(W_MAX)) ? WW'(W_MAX) : wr_w;
                end
                mp2d_pkg::REG_CHANNEL_COUNT:
                begin
                    cfg_next.channel_count = (wr_c == '0) ? KW'(1)
                        : (wr_c > KW'(mp2d_pkg::C_LIMIT)) ? KW'(mp2d_pkg::C_LIMIT) : wr_c;
                end
                mp2d_pkg::REG_POOL_SIZE:
                begin
                    cfg_next.pool_size = (wr_p == '0) ? PW'(1)
                        : (wr_p > PW'(P_MAX)) ? PW'(P_MAX) : wr_p;
                end
                mp2d_pkg::REG_POOL_STRIDE:
                begin
                    cfg_next.pool_stride = (wr_s == '0) ? PW'(1)
                        : (wr_s > PW'(mp2d_pkg::S_LIMIT)) ? PW'(mp2d_pkg::S_LIMIT) : wr_s;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height  <= HW'(1);
            cfg_reg.image_width   <= WW'(1);
            cfg_reg.channel_count <= KW'(1);
            cfg_reg.pool_size     <= PW'(2);
            cfg_reg.pool_stride   <= PW'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mp2d_pos #(
        .MAX_POOL(MAX_POOL)
    ) u_pos (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_reg),
        .step (step),
        .info (info),
        .slot (slot)
    );

    mp2d_win #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_POOL (MAX_POOL)
    ) u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .info      (info),
        .slot      (slot),
        .pool_size (cfg_reg.pool_size),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pooled    (pooled),
        .tensor_end(tensor_end)
    );

endmodule

`default_nettype wire
